[rtl/core/dla_pkg.sv]
// Shared constants, types and the quarter-wave sine table of the aggregation walker.
package dla_pkg;

    localparam int GRID_SIZE    = 1024;
    localparam int ANGLE_STEPS  = 1024;
    localparam int COORD_W      = $clog2(GRID_SIZE);
    localparam int ANG_W        = $clog2(ANGLE_STEPS);
    localparam int QTR          = ANGLE_STEPS / 4;
    localparam int QTR_W        = ANG_W - 2;
    localparam int CENTRE       = GRID_SIZE / 2;
    localparam int RAD_W        = 16;
    localparam int RAD_MAX      = (1 << RAD_W) - 1;
    localparam int RADIUS_START = 1280;
    localparam int CNT_W        = 21;
    localparam int THR_W        = 17;
    localparam int DRAW_W       = 16;
    localparam int THR_RESET    = 65536;
    localparam int FULL_LIMIT   = (GRID_SIZE / 2) * 256;
    localparam int D2_W         = 2 * COORD_W;
    localparam int SQ_W         = D2_W + 16;
    localparam int SQ_STEPS     = SQ_W / 2;
    localparam int SIN_W        = 15;
    localparam int TRIG_W       = 16;
    localparam int RS_W         = RAD_W + 2;
    localparam int PROD_W       = RS_W + TRIG_W;
    localparam int PROD_SHIFT   = 22;

    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    typedef enum logic [1:0] {
        DIR_PX = 2'd0,
        DIR_PY = 2'd1,
        DIR_NX = 2'd2,
        DIR_NY = 2'd3
    } t_dir;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] operand;
    } t_sqrt_req;

    typedef struct packed {
        logic                done;
        logic [SQ_STEPS-1:0] root;
    } t_sqrt_rsp;

    typedef logic [QTR:0][SIN_W-1:0] t_sin_tab;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // sin(r / ANGLE_STEPS * pi/2) in Q14: Horner Taylor series in Q30
    function automatic longint unsigned quarter_sin(longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = r * HALF_PI_Q30 / ANGLE_STEPS;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (((x * t) >> 30) + 32768) >> 16;
        if (s > 16384) begin
            s = 16384;
        end
        if (r == 0) begin
            s = 0;
        end
        if (r >= ANGLE_STEPS) begin
            s = 16384;
        end
        return s;
    endfunction

    // spawn angles only land on multiples of four within a quadrant
    function automatic t_sin_tab sin_tab_build();
        t_sin_tab tab;
        for (int k = 0; k <= QTR; k++) begin
            tab[k] = SIN_W'(quarter_sin(longint'(4 * k)));
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = sin_tab_build();

endpackage

[rtl/core/dla_walker_step.sv]
// Diffusion-limited aggregation walker: one tick or restart per input beat.
// A tick reads the target row, moves and checks the distance; a failed stick draw ends there,
// a pass reads the neighbor rows first; a stray respawns and checks again, a stick respawns
// after a radius square root when the cluster grows; a restart clears one grid row a cycle,
// then spawns. One item at a time: the input stalls from accept until the result is loaded.
// Reset (synchronous, active low) acts as a restart at angle 0: a clearing pass of every row
// runs first, with the input stalled and no result beat produced.
module dla_walker_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_kind,
    input  logic [1:0]                  i_move_dir,
    input  logic [dla_pkg::DRAW_W-1:0]  i_stick_draw,
    input  logic [dla_pkg::ANG_W-1:0]   i_spawn_angle,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [dla_pkg::COORD_W-1:0] o_walker_x,
    output logic [dla_pkg::COORD_W-1:0] o_walker_y,
    output logic                        o_stuck,
    output logic                        o_was_lost,
    output logic [dla_pkg::CNT_W-1:0]   o_particle_count,
    output logic [dla_pkg::RAD_W-1:0]   o_cluster_radius,
    output logic                        o_grid_full,
    // configuration: stick threshold
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dla_pkg::THR_W-1:0]   i_cfg_stick_threshold
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOVE,
        ST_DIST,
        ST_CHECK,
        ST_SPAWN_A,
        ST_SPAWN_B,
        ST_SPAWN_C,
        ST_NB_A,
        ST_NB_B,
        ST_NB_C,
        ST_NB_D,
        ST_SQRT,
        ST_FINISH
    } t_state;

    localparam int CW = dla_pkg::COORD_W;
    localparam logic [CW-1:0] C_CENTRE = CW'(dla_pkg::CENTRE);
    localparam logic [CW-1:0] C_LAST   = CW'(dla_pkg::GRID_SIZE - 1);
    localparam logic [dla_pkg::CNT_W-1:0] C_CNT_MAX = '1;

    t_state                          r_state;
    logic [CW-1:0]                   r_x;
    logic [CW-1:0]                   r_y;
    logic [CW-1:0]                   r_tx;
    logic [CW-1:0]                   r_ty;
    logic                            r_tgt_ok;
    logic [dla_pkg::RAD_W-1:0]       r_radius;
    logic [dla_pkg::CNT_W-1:0]       r_count;
    logic                            r_full;
    logic [dla_pkg::THR_W-1:0]       r_thr;
    logic [dla_pkg::DRAW_W-1:0]      r_draw;
    logic [dla_pkg::ANG_W-1:0]       r_angle;
    logic [2*dla_pkg::RAD_W-1:0]     r_r2;
    logic [dla_pkg::D2_W-1:0]        r_d2;
    logic                            r_lost_seen;
    logic                            r_lost;
    logic                            r_stuck;
    logic                            r_ret_dist;
    logic                            r_emit;
    logic [CW-1:0]                   r_clr;
    logic                            r_nb;
    logic signed [dla_pkg::TRIG_W-1:0] r_c;
    logic signed [dla_pkg::TRIG_W-1:0] r_s;
    logic signed [dla_pkg::PROD_W-1:0] r_px;
    logic signed [dla_pkg::PROD_W-1:0] r_py;

    logic                            r_out_valid;
    logic [CW-1:0]                   r_out_x;
    logic [CW-1:0]                   r_out_y;
    logic                            r_out_stuck;
    logic                            r_out_lost;
    logic [dla_pkg::CNT_W-1:0]       r_out_count;
    logic [dla_pkg::RAD_W-1:0]       r_out_radius;
    logic                            r_out_full;

    logic                            in_acc;
    logic [CW:0]                     n_tx;
    logic [CW:0]                     n_ty;
    logic                            ram_we;
    logic [CW-1:0]                   ram_waddr;
    logic [dla_pkg::GRID_SIZE-1:0]   ram_wdata;
    logic [CW-1:0]                   ram_raddr;
    logic [dla_pkg::GRID_SIZE-1:0]   ram_rdata;
    logic [dla_pkg::GRID_SIZE-1:0]   row_bit;
    logic signed [dla_pkg::D2_W-1:0] dx;
    logic signed [dla_pkg::D2_W-1:0] dy;
    logic [dla_pkg::D2_W-1:0]        n_d2;
    logic [dla_pkg::SQ_W-1:0]        d2_sh;
    logic [dla_pkg::SQ_W-1:0]        r2_ext;
    logic                            lost_now;
    logic                            grow;
    logic                            stick_pass;
    logic                            full_now;
    logic                            nb_any;
    logic                            self_set;
    logic [dla_pkg::QTR_W-1:0]       ang_k;
    logic [dla_pkg::QTR_W:0]         ang_kc;
    logic signed [dla_pkg::TRIG_W-1:0] sin_a;
    logic signed [dla_pkg::TRIG_W-1:0] sin_b;
    logic signed [dla_pkg::RS_W-1:0] rs;
    logic signed [dla_pkg::PROD_W-1:0] sx;
    logic signed [dla_pkg::PROD_W-1:0] sy;
    logic [CW-1:0]                   clamp_x;
    logic [CW-1:0]                   clamp_y;
    dla_pkg::t_sqrt_req              sq_req;
    dla_pkg::t_sqrt_rsp              sq_rsp;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // move target; a step off either edge sets the extra top bit
    always_comb begin
        n_tx = {1'b0, r_x};
        n_ty = {1'b0, r_y};
        case (dla_pkg::t_dir'(i_move_dir))
            dla_pkg::DIR_PX: n_tx = {1'b0, r_x} + (CW+1)'(1);
            dla_pkg::DIR_PY: n_ty = {1'b0, r_y} + (CW+1)'(1);
            dla_pkg::DIR_NX: n_tx = {1'b0, r_x} - (CW+1)'(1);
            default:         n_ty = {1'b0, r_y} - (CW+1)'(1);
        endcase
    end

    // occupancy row port: one row read per cycle, read-modify-write on stick
    assign row_bit = dla_pkg::GRID_SIZE'(1) << r_y;

    always_comb begin
        unique case (r_state)
            ST_IDLE: ram_raddr = n_tx[CW-1:0];
            ST_NB_A: ram_raddr = r_x - CW'(1);
            ST_NB_B: ram_raddr = r_x + CW'(1);
            default: ram_raddr = r_x;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_x;
        ram_wdata = ram_rdata | row_bit;
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = (r_clr == C_CENTRE) ? (dla_pkg::GRID_SIZE'(1) << C_CENTRE) : '0;
        end else if (r_state == ST_NB_D) begin
            ram_we = nb_any && !self_set;
        end
    end

    dla_ram #(
        .WIDTH (dla_pkg::GRID_SIZE),
        .DEPTH (dla_pkg::GRID_SIZE)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // squared distance from the centre and the stray / grow tests
    assign dx     = $signed(dla_pkg::D2_W'(r_x)) - $signed(dla_pkg::D2_W'(C_CENTRE));
    assign dy     = $signed(dla_pkg::D2_W'(r_y)) - $signed(dla_pkg::D2_W'(C_CENTRE));
    assign n_d2   = $unsigned(dx * dx) + $unsigned(dy * dy);
    assign d2_sh  = {r_d2, 16'b0};
    assign r2_ext = dla_pkg::SQ_W'(r_r2);
    assign lost_now   = d2_sh > ((r2_ext << 3) + r2_ext);
    assign grow       = d2_sh > r2_ext;
    assign stick_pass = {1'b0, r_draw} < r_thr;
    assign full_now   = (32'(r_radius) * 32'd3) > 32'(dla_pkg::FULL_LIMIT);

    // neighbors: rows x-1 and x+1 were sampled into r_nb, row x is on the read port now
    assign self_set = ram_rdata[r_y];
    assign nb_any   = r_nb
                   || ((r_y != C_LAST) && ram_rdata[r_y + CW'(1)])
                   || ((r_y != '0) && ram_rdata[r_y - CW'(1)]);

    // spawn direction from the quarter-wave table
    assign ang_k  = r_angle[dla_pkg::QTR_W-1:0];
    assign ang_kc = (dla_pkg::QTR_W+1)'(dla_pkg::QTR) - {1'b0, ang_k};
    assign sin_a  = $signed({1'b0, dla_pkg::SIN_TAB[ang_k]});
    assign sin_b  = $signed({1'b0, dla_pkg::SIN_TAB[ang_kc]});
    assign rs     = $signed({2'b0, r_radius} + dla_pkg::RS_W'(dla_pkg::RADIUS_START));

    // arithmetic shift floors toward minus infinity
    assign sx = (r_px >>> dla_pkg::PROD_SHIFT) + dla_pkg::PROD_W'(dla_pkg::CENTRE);
    assign sy = (r_py >>> dla_pkg::PROD_SHIFT) + dla_pkg::PROD_W'(dla_pkg::CENTRE);

    always_comb begin
        if (sx < 0) begin
            clamp_x = '0;
        end else if (sx >= dla_pkg::PROD_W'(dla_pkg::GRID_SIZE)) begin
            clamp_x = C_LAST;
        end else begin
            clamp_x = sx[CW-1:0];
        end
        if (sy < 0) begin
            clamp_y = '0;
        end else if (sy >= dla_pkg::PROD_W'(dla_pkg::GRID_SIZE)) begin
            clamp_y = C_LAST;
        end else begin
            clamp_y = sy[CW-1:0];
        end
    end

    assign sq_req.start   = (r_state == ST_NB_D) && nb_any && grow;
    assign sq_req.operand = d2_sh;

    dla_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_x         <= C_CENTRE;
            r_y         <= C_CENTRE;
            r_radius    <= dla_pkg::RAD_W'(dla_pkg::RADIUS_START);
            r_count     <= dla_pkg::CNT_W'(1);
            r_full      <= 1'b0;
            r_thr       <= dla_pkg::THR_W'(dla_pkg::THR_RESET);
            r_angle     <= '0;
            r_emit      <= 1'b0;
            r_ret_dist  <= 1'b0;
            r_lost_seen <= 1'b0;
            r_lost      <= 1'b0;
            r_stuck     <= 1'b0;
            r_nb        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_stick_threshold;
            end
            // drop the result once the consumer takes it, unless a new one loads now
            if (r_out_valid && !i_out_stall && !((r_state == ST_FINISH) && r_emit)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + CW'(1);
                    if (r_clr == C_LAST) begin
                        r_state <= ST_SPAWN_A;
                    end
                end

                ST_IDLE: begin
                    if (in_acc) begin
                        r_emit      <= 1'b1;
                        r_stuck     <= 1'b0;
                        r_lost      <= 1'b0;
                        r_lost_seen <= 1'b0;
                        r_ret_dist  <= 1'b0;
                        r_draw      <= i_stick_draw;
                        r_angle     <= i_spawn_angle;
                        r_tx        <= n_tx[CW-1:0];
                        r_ty        <= n_ty[CW-1:0];
                        r_tgt_ok    <= !n_tx[CW] && !n_ty[CW];
                        if (i_kind == dla_pkg::KIND_RESTART) begin
                            r_radius <= dla_pkg::RAD_W'(dla_pkg::RADIUS_START);
                            r_count  <= dla_pkg::CNT_W'(1);
                            r_full   <= 1'b0;
                            r_x      <= C_CENTRE;
                            r_y      <= C_CENTRE;
                            r_clr    <= '0;
                            r_state  <= ST_CLEAR;
                        end else if (r_full) begin
                            r_state <= ST_FINISH;
                        end else begin
                            r_state <= ST_MOVE;
                        end
                    end
                end

                ST_MOVE: begin
                    // target row is on the read port; advance only into an empty cell
                    if (r_tgt_ok && !ram_rdata[r_ty]) begin
                        r_x <= r_tx;
                        r_y <= r_ty;
                    end
                    r_r2    <= r_radius * r_radius;
                    r_state <= ST_DIST;
                end

                ST_DIST: begin
                    r_d2    <= n_d2;
                    r_state <= ST_CHECK;
                end

                ST_CHECK: begin
                    r_lost_seen <= 1'b1;
                    if (!r_lost_seen && lost_now) begin
                        r_lost     <= 1'b1;
                        r_ret_dist <= 1'b1;
                        r_state    <= ST_SPAWN_A;
                    end else if (stick_pass) begin
                        r_state <= ST_NB_A;
                    end else begin
                        r_state <= ST_FINISH;
                    end
                end

                ST_SPAWN_A: begin
                    if (full_now) begin
                        // spawn would leave the grid: hold the walker, skip the rest
                        r_full     <= 1'b1;
                        r_ret_dist <= 1'b0;
                        r_state    <= ST_FINISH;
                    end else begin
                        case (r_angle[dla_pkg::ANG_W-1:dla_pkg::QTR_W])
                            2'd0: begin
                                r_s <= sin_a;
                                r_c <= sin_b;
                            end
                            2'd1: begin
                                r_s <= sin_b;
                                r_c <= -sin_a;
                            end
                            2'd2: begin
                                r_s <= -sin_a;
                                r_c <= -sin_b;
                            end
                            default: begin
                                r_s <= -sin_b;
                                r_c <= sin_a;
                            end
                        endcase
                        r_state <= ST_SPAWN_B;
                    end
                end

                ST_SPAWN_B: begin
                    r_px    <= rs * r_c;
                    r_py    <= rs * r_s;
                    r_state <= ST_SPAWN_C;
                end

                ST_SPAWN_C: begin
                    r_x        <= clamp_x;
                    r_y        <= clamp_y;
                    r_ret_dist <= 1'b0;
                    r_state    <= r_ret_dist ? ST_DIST : ST_FINISH;
                end

                ST_NB_A: begin
                    r_state <= ST_NB_B;
                end

                ST_NB_B: begin
                    r_nb    <= (r_x != '0) && ram_rdata[r_y];
                    r_state <= ST_NB_C;
                end

                ST_NB_C: begin
                    r_nb    <= r_nb || ((r_x != C_LAST) && ram_rdata[r_y]);
                    r_state <= ST_NB_D;
                end

                ST_NB_D: begin
                    if (nb_any) begin
                        r_stuck <= 1'b1;
                        if (!self_set && (r_count != C_CNT_MAX)) begin
                            r_count <= r_count + dla_pkg::CNT_W'(1);
                        end
                        r_state <= grow ? ST_SQRT : ST_SPAWN_A;
                    end else begin
                        r_state <= ST_FINISH;
                    end
                end

                ST_SQRT: begin
                    if (sq_rsp.done) begin
                        if (|sq_rsp.root[dla_pkg::SQ_STEPS-1:dla_pkg::RAD_W]) begin
                            r_radius <= dla_pkg::RAD_W'(dla_pkg::RAD_MAX);
                        end else begin
                            r_radius <= sq_rsp.root[dla_pkg::RAD_W-1:0];
                        end
                        r_state <= ST_SPAWN_A;
                    end
                end

                ST_FINISH: begin
                    if (!r_emit) begin
                        r_state <= ST_IDLE;
                    end else if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_x      <= r_x;
                        r_out_y      <= r_y;
                        r_out_stuck  <= r_stuck;
                        r_out_lost   <= r_lost;
                        r_out_count  <= r_count;
                        r_out_radius <= r_radius;
                        r_out_full   <= r_full;
                        r_emit       <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_walker_x       = r_out_x;
    assign o_walker_y       = r_out_y;
    assign o_stuck          = r_out_stuck;
    assign o_was_lost       = r_out_lost;
    assign o_particle_count = r_out_count;
    assign o_cluster_radius = r_out_radius;
    assign o_grid_full      = r_out_full;

endmodule

[rtl/core/dla_ram.sv]
// Generic simple dual-port RAM with registered read data.
module dla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/dla_sqrt.sv]
// Bit-serial integer square root, two operand bits per cycle.
module dla_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dla_pkg::t_sqrt_req i_req,
    output dla_pkg::t_sqrt_rsp o_rsp
);

    logic                     r_busy;
    logic                     r_done;
    logic [dla_pkg::SQ_W-1:0] r_v;
    logic [dla_pkg::SQ_W-1:0] r_res;
    logic [dla_pkg::SQ_W-1:0] r_bit;
    logic [dla_pkg::SQ_W-1:0] n_trial;

    assign n_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_v    <= i_req.operand;
                r_res  <= '0;
                r_bit  <= dla_pkg::SQ_W'(1) << (dla_pkg::SQ_W - 2);
            end else if (r_busy) begin
                if (r_v >= n_trial) begin
                    r_v   <= r_v - n_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == dla_pkg::SQ_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res[dla_pkg::SQ_STEPS-1:0];

endmodule

[rtl/core/dla_chk.sv]
// Port-level checker for the aggregation walker, bound to every dla_walker_step instance.
module dla_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [dla_pkg::COORD_W-1:0] o_walker_x,
    input logic [dla_pkg::COORD_W-1:0] o_walker_y,
    input logic [dla_pkg::CNT_W-1:0]   o_particle_count,
    input logic [dla_pkg::RAD_W-1:0]   o_cluster_radius
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_walker_x)
            && $stable(o_walker_y) && $stable(o_particle_count))
        else $error("stalled result beat changed");

    // one item at a time: the input stalls right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // the centre seed is always part of the aggregate
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_particle_count != '0)
        else $error("particle count is zero");

    // the radius only grows from its start value
    a_radius_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cluster_radius >= dla_pkg::RAD_W'(dla_pkg::RADIUS_START))
        else $error("cluster radius below start value");

endmodule

bind dla_walker_step dla_chk u_dla_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_walker_x       (o_walker_x),
    .o_walker_y       (o_walker_y),
    .o_particle_count (o_particle_count),
    .o_cluster_radius (o_cluster_radius)
);

[dv/dla_walker_checker.sv]
// Checker for the aggregation walker: tracks the grid, predicts each result beat and compares.
module dla_walker_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_kind,
    input  logic [1:0]                  i_move_dir,
    input  logic [dla_pkg::DRAW_W-1:0]  i_stick_draw,
    input  logic [dla_pkg::ANG_W-1:0]   i_spawn_angle,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [dla_pkg::COORD_W-1:0] i_walker_x,
    input  logic [dla_pkg::COORD_W-1:0] i_walker_y,
    input  logic                        i_stuck,
    input  logic                        i_was_lost,
    input  logic [dla_pkg::CNT_W-1:0]   i_particle_count,
    input  logic [dla_pkg::RAD_W-1:0]   i_cluster_radius,
    input  logic                        i_grid_full,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [dla_pkg::THR_W-1:0]   i_cfg_stick_threshold,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_stuck_seen,
    output int                          o_lost_seen,
    output int                          o_full_seen
);

    typedef struct packed {
        logic [dla_pkg::COORD_W-1:0] wx;
        logic [dla_pkg::COORD_W-1:0] wy;
        logic                        stuck;
        logic                        lost;
        logic [dla_pkg::CNT_W-1:0]   count;
        logic [dla_pkg::RAD_W-1:0]   radius;
        logic                        full;
    } t_walk_result;

    t_walk_result expected_beats[$];
    bit           grid[dla_pkg::GRID_SIZE*dla_pkg::GRID_SIZE];
    int           pos_x, pos_y;
    int unsigned  radius_q8, particles, threshold;
    bit           full;

    function automatic longint wave(longint unsigned r);
        longint unsigned x, x2, t, s;
        if (r == 0) return 0;
        if (r >= dla_pkg::ANGLE_STEPS) return 16384;
        x  = r * 64'd1686629713 / dla_pkg::ANGLE_STEPS;
        x2 = (x * x) >> 30;
        t  = (64'd1 << 30) - x2 / 72;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
        s  = (((x * t) >> 30) + 32768) >> 16;
        if (s > 16384) s = 16384;
        return longint'(s);
    endfunction

    function automatic longint floor22(longint p);
        if (p >= 0) return p >>> 22;
        return -((-p + 4194303) >>> 22);
    endfunction

    function automatic int clamp(longint v);
        if (v < 0) return 0;
        if (v >= dla_pkg::GRID_SIZE) return dla_pkg::GRID_SIZE - 1;
        return int'(v);
    endfunction

    function automatic bit occupied(int x, int y);
        if (x < 0 || y < 0 || x >= dla_pkg::GRID_SIZE || y >= dla_pkg::GRID_SIZE) return 0;
        return grid[x*dla_pkg::GRID_SIZE + y];
    endfunction

    function automatic longint unsigned centre_dist2();
        longint dx, dy;
        dx = pos_x - dla_pkg::CENTRE;
        dy = pos_y - dla_pkg::CENTRE;
        return longint'(dx*dx + dy*dy);
    endfunction

    function automatic longint unsigned root_of(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // place the walker on the launch circle; flag full when it would leave the grid
    function automatic bit launch(int unsigned ang);
        int unsigned q, r;
        longint c, s, rs;
        q = (4 * ang) / dla_pkg::ANGLE_STEPS;
        r = (4 * ang) % dla_pkg::ANGLE_STEPS;
        if (longint'(radius_q8) * 3 > dla_pkg::FULL_LIMIT) begin
            full = 1;
            return 0;
        end
        case (q)
            0: begin s = wave(r); c = wave(dla_pkg::ANGLE_STEPS - r); end
            1: begin s = wave(dla_pkg::ANGLE_STEPS - r); c = -wave(r); end
            2: begin s = -wave(r); c = -wave(dla_pkg::ANGLE_STEPS - r); end
            default: begin s = -wave(dla_pkg::ANGLE_STEPS - r); c = wave(r); end
        endcase
        rs = longint'(radius_q8) + 1280;
        pos_x = clamp(dla_pkg::CENTRE + floor22(rs * c));
        pos_y = clamp(dla_pkg::CENTRE + floor22(rs * s));
        return 1;
    endfunction

    function automatic void clear_aggregate(int unsigned ang);
        foreach (grid[i]) grid[i] = 0;
        grid[dla_pkg::CENTRE*dla_pkg::GRID_SIZE + dla_pkg::CENTRE] = 1;
        radius_q8 = dla_pkg::RADIUS_START;
        particles = 1;
        full = 0;
        pos_x = dla_pkg::CENTRE;
        pos_y = dla_pkg::CENTRE;
        void'(launch(ang));
    endfunction

    function automatic t_walk_result walk_tick(logic kind, logic [1:0] dir,
                                               int unsigned draw, int unsigned ang);
        t_walk_result res;
        int tx, ty;
        bit alive, stuck, lost;
        longint unsigned d2, nr;
        stuck = 0;
        lost  = 0;
        alive = 1;
        if (kind == dla_pkg::KIND_RESTART) begin
            clear_aggregate(ang);
        end else if (!full) begin
            tx = pos_x;
            ty = pos_y;
            case (dla_pkg::t_dir'(dir))
                dla_pkg::DIR_PX: tx++;
                dla_pkg::DIR_PY: ty++;
                dla_pkg::DIR_NX: tx--;
                default:         ty--;
            endcase
            if (tx >= 0 && ty >= 0 && tx < dla_pkg::GRID_SIZE && ty < dla_pkg::GRID_SIZE
                && !occupied(tx, ty)) begin
                pos_x = tx;
                pos_y = ty;
            end
            if (centre_dist2() * 65536 > 9 * longint'(radius_q8) * radius_q8) begin
                lost  = 1;
                alive = launch(ang);
            end
            if (alive && draw < threshold) begin
                if (occupied(pos_x+1, pos_y) || occupied(pos_x-1, pos_y) ||
                    occupied(pos_x, pos_y+1) || occupied(pos_x, pos_y-1)) begin
                    d2 = centre_dist2() * 65536;
                    stuck = 1;
                    if (!occupied(pos_x, pos_y)) begin
                        grid[pos_x*dla_pkg::GRID_SIZE + pos_y] = 1;
                        if (particles < 2097151) particles++;
                    end
                    if (d2 > longint'(radius_q8) * radius_q8) begin
                        nr = root_of(d2);
                        radius_q8 = (nr > dla_pkg::RAD_MAX) ? dla_pkg::RAD_MAX : int'(nr);
                    end
                    void'(launch(ang));
                end
            end
        end
        res.wx = dla_pkg::COORD_W'(pos_x);
        res.wy = dla_pkg::COORD_W'(pos_y);
        res.stuck = stuck;
        res.lost = lost;
        res.count = dla_pkg::CNT_W'(particles);
        res.radius = dla_pkg::RAD_W'(radius_q8);
        res.full = full;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    assign o_pending = expected_beats.size();

    always @(posedge i_clk) begin
        t_walk_result want;
        if (!i_rst_n) begin
            o_errors     = 0;
            o_stuck_seen = 0;
            o_lost_seen  = 0;
            o_full_seen  = 0;
            threshold    = dla_pkg::THR_RESET;
            clear_aggregate(0);
        end else begin
            if (i_cfg_valid && i_cfg_ready) threshold = 32'(i_cfg_stick_threshold);
            if (i_in_valid && !i_in_stall)
                expected_beats.push_back(walk_tick(i_kind, i_move_dir,
                                                   32'(i_stick_draw), 32'(i_spawn_angle)));
            if (i_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_walker_x != want.wx) report_mismatch("walker_x", i_walker_x, want.wx);
                    if (i_walker_y != want.wy) report_mismatch("walker_y", i_walker_y, want.wy);
                    if (i_stuck != want.stuck) report_mismatch("stuck", i_stuck, want.stuck);
                    if (i_was_lost != want.lost)
                        report_mismatch("was_lost", i_was_lost, want.lost);
                    if (i_particle_count != want.count)
                        report_mismatch("particle_count", i_particle_count, want.count);
                    if (i_cluster_radius != want.radius)
                        report_mismatch("cluster_radius", i_cluster_radius, want.radius);
                    if (i_grid_full != want.full)
                        report_mismatch("grid_full", i_grid_full, want.full);
                    o_stuck_seen += want.stuck;
                    o_lost_seen  += want.lost;
                    o_full_seen  += want.full;
                end
            end
        end
    end
endmodule

[dv/tb_top.sv]
// Testbench top for the aggregation walker: stimulus, backpressure and verdict.
module tb_top;

    logic                         i_clk = 0;
    logic                         i_rst_n = 0;
    logic                         in_valid = 0;
    logic                         in_stall;
    logic                         kind = dla_pkg::KIND_TICK;
    logic [1:0]                   move_dir = dla_pkg::DIR_PX;
    logic [dla_pkg::DRAW_W-1:0]   stick_draw = '0;
    logic [dla_pkg::ANG_W-1:0]    spawn_angle = '0;
    logic                         out_valid;
    logic                         out_stall = 0;
    logic [dla_pkg::COORD_W-1:0]  walker_x, walker_y;
    logic                         stuck, was_lost, grid_full;
    logic [dla_pkg::CNT_W-1:0]    particle_count;
    logic [dla_pkg::RAD_W-1:0]    cluster_radius;
    logic                         cfg_valid = 0;
    logic                         cfg_ready;
    logic [dla_pkg::THR_W-1:0]    cfg_threshold = '0;
    int                           errors, pending, stuck_seen, lost_seen, full_seen;
    longint                       cycles = 0;
    bit                           hold_off = 0;
    int                           items_sent = 0;

    // Generous: ~1700 items plus long stalls and restarts, each with a full grid clear.
    localparam longint CYCLE_LIMIT = 3_000_000;

    always #5 i_clk = ~i_clk;

    dla_walker_step u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (in_valid),
        .o_in_stall            (in_stall),
        .i_kind                (kind),
        .i_move_dir            (move_dir),
        .i_stick_draw          (stick_draw),
        .i_spawn_angle         (spawn_angle),
        .o_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .o_walker_x            (walker_x),
        .o_walker_y            (walker_y),
        .o_stuck               (stuck),
        .o_was_lost            (was_lost),
        .o_particle_count      (particle_count),
        .o_cluster_radius      (cluster_radius),
        .o_grid_full           (grid_full),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (cfg_ready),
        .i_cfg_stick_threshold (cfg_threshold)
    );

    dla_walker_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_kind(kind),
        .i_move_dir(move_dir), .i_stick_draw(stick_draw), .i_spawn_angle(spawn_angle),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_walker_x(walker_x), .i_walker_y(walker_y), .i_stuck(stuck),
        .i_was_lost(was_lost), .i_particle_count(particle_count),
        .i_cluster_radius(cluster_radius), .i_grid_full(grid_full),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_stick_threshold(cfg_threshold),
        .o_errors(errors), .o_pending(pending), .o_stuck_seen(stuck_seen),
        .o_lost_seen(lost_seen), .o_full_seen(full_seen)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stall: random gaps, plus one long hold-off when asked.
    initial begin
        int n;
        bit held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off && !held) begin
                out_stall <= 1;
                repeat (400) @(posedge i_clk);
                held = 1;
            end
            n = gap_len();
            if (n == 0 || $urandom_range(0, 3) != 0) begin
                out_stall <= 0;
            end else begin
                out_stall <= 1;
                repeat (n - 1) @(posedge i_clk);
            end
        end
    end

    // Offer one beat; hold it steady until accepted, then drop valid for a gap unless no_gap is set.
    task automatic send_beat(logic k, logic [1:0] d, logic [dla_pkg::DRAW_W-1:0] draw,
                             logic [dla_pkg::ANG_W-1:0] ang, bit no_gap);
        int n;
        kind        <= k;
        move_dir    <= d;
        stick_draw  <= draw;
        spawn_angle <= ang;
        in_valid    <= 1;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
        n = no_gap ? 0 : gap_len();
        if (n > 0) begin
            in_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic tick(logic [1:0] d, logic [dla_pkg::DRAW_W-1:0] draw,
                        logic [dla_pkg::ANG_W-1:0] ang);
        send_beat(dla_pkg::KIND_TICK, d, draw, ang, 0);
    endtask

    // Drain, let the block settle, then write the threshold.
    task automatic write_threshold(logic [dla_pkg::THR_W-1:0] value);
        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        cfg_threshold <= value;
        cfg_valid     <= 1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    // Walk inward toward the centre with random detours, so sticking happens.
    function automatic logic [1:0] inward_dir();
        int dx, dy;
        dx = int'(walker_x) - dla_pkg::CENTRE;
        dy = int'(walker_y) - dla_pkg::CENTRE;
        if ($urandom_range(0, 9) < 3) return 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0 && dx != 0)
            return dx > 0 ? dla_pkg::DIR_NX : dla_pkg::DIR_PX;
        if (dy != 0) return dy > 0 ? dla_pkg::DIR_NY : dla_pkg::DIR_PY;
        return dx > 0 ? dla_pkg::DIR_NX : dla_pkg::DIR_PX;
    endfunction

    initial begin
        logic [dla_pkg::THR_W-1:0] thr_set[5];
        thr_set = '{17'd65536, 17'd0, 17'd131071, 17'd32768, 17'd65535};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: field extremes, both kinds, every direction, stray and angle ends.
        send_beat(dla_pkg::KIND_RESTART, dla_pkg::DIR_PX, 16'd0, 10'd0, 0);
        tick(dla_pkg::DIR_PX, 16'hFFFF, 10'd1023);
        tick(dla_pkg::DIR_NX, 16'd0, 10'd0);
        tick(dla_pkg::DIR_NX, 16'd0, 10'd255);
        tick(dla_pkg::DIR_PY, 16'd1, 10'd256);
        tick(dla_pkg::DIR_NY, 16'hFFFF, 10'd512);
        for (int i = 0; i < 8; i++) tick(dla_pkg::DIR_PX, 16'hFFFF, 10'd768);  // stray outward
        send_beat(dla_pkg::KIND_RESTART, dla_pkg::DIR_NY, 16'hFFFF, 10'd1023, 0);
        for (int i = 0; i < 6; i++) tick(dla_pkg::DIR_NX, 16'd0, 10'h2AA);
        send_beat(dla_pkg::KIND_RESTART, dla_pkg::DIR_PX, 16'hAAAA, 10'h155, 0);
        tick(dla_pkg::DIR_PX, 16'h5555, 10'h3FF);

        // Random phases, one per threshold setting.
        foreach (thr_set[p]) begin
            write_threshold(thr_set[p]);
            if (p == 2) hold_off = 1;  // receiver backs up while we keep offering
            for (int i = 0; i < 340; i++) begin
                int roll;
                roll = $urandom_range(0, 999);
                if (roll < 4)
                    send_beat(dla_pkg::KIND_RESTART, 2'($urandom_range(0, 3)),
                              dla_pkg::DRAW_W'($urandom), dla_pkg::ANG_W'($urandom), 0);
                else if (roll < 820)
                    send_beat(dla_pkg::KIND_TICK, inward_dir(), dla_pkg::DRAW_W'($urandom),
                              dla_pkg::ANG_W'($urandom), $urandom_range(0, 3) == 0);
                else
                    send_beat(dla_pkg::KIND_TICK, 2'($urandom_range(0, 3)),
                              dla_pkg::DRAW_W'($urandom), dla_pkg::ANG_W'($urandom), 0);
            end
        end
        in_valid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d beats over 5 thresholds: %0d stuck, %0d lost, %0d full",
                 items_sent, stuck_seen, lost_seen, full_seen);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/core/dla_pkg.sv
rtl/core/dla_ram.sv
rtl/core/dla_sqrt.sv
rtl/core/dla_walker_step.sv
rtl/core/dla_chk.sv
dv/dla_walker_checker.sv
dv/tb_top.sv
